// ===== hdl/strw_pkg.sv =====
// strw_pkg: shared types, constants and codes for the snapshot trigger block
// used by strw_regs, strw_ctrl, strw_dp and snapshot_trigger_rate_window_top
`timescale 1ns / 1ps

package strw_pkg;

    // depth of the stored time history
    localparam int HIST_DEPTH = 256;
    localparam int HEAD_W     = $clog2(HIST_DEPTH);
    localparam int FILL_W     = $clog2(HIST_DEPTH + 1);

    localparam int TIME_W  = 32;
    localparam int COUNT_W = 32;
    localparam int BURST_W = 8;
    localparam int WIN_W   = 16;
    localparam int WC_W    = 9;
    localparam int CAUSE_W = 3;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 48;

    // configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_INTERVAL = 2'd0;
    localparam logic [1:0] REG_BURST    = 2'd1;
    localparam logic [1:0] REG_WINDOW   = 2'd2;

    localparam logic [COUNT_W-1:0] INTERVAL_RST = 32'd1000;
    localparam logic [BURST_W-1:0] BURST_RST    = 8'd100;
    localparam logic [WIN_W-1:0]   WINDOW_RST   = 16'd1000;

    // request kinds
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_FORCE = 1'b1;

    // snapshot causes
    localparam logic [CAUSE_W-1:0] CAUSE_NONE   = 3'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_COUNT  = 3'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_BURST  = 3'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_BOTH   = 3'd3;
    localparam logic [CAUSE_W-1:0] CAUSE_FORCED = 3'd4;

    typedef struct packed {
        logic [COUNT_W-1:0] interval;
        logic [BURST_W-1:0] burst;
        logic [WIN_W-1:0]   window;
    } strw_cfg_t;

    typedef struct packed {
        logic start;
        logic walk;
        logic finish;
    } strw_cmd_t;

    typedef struct packed {
        logic walk_done;
        logic out_busy;
    } strw_stat_t;

endpackage

// ===== hdl/strw_regs.sv =====
// strw_regs: configuration register file behind the apb-style port
// depends on strw_pkg
`timescale 1ns / 1ps

module strw_regs
    import strw_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output strw_cfg_t         cfg
);

    logic [COUNT_W-1:0] interval_reg;
    logic [BURST_W-1:0] burst_reg;
    logic [WIN_W-1:0]   window_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= INTERVAL_RST;
            burst_reg    <= BURST_RST;
            window_reg   <= WINDOW_RST;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_INTERVAL: interval_reg <= pwdata[COUNT_W-1:0];
                REG_BURST:    burst_reg    <= pwdata[BURST_W-1:0];
                REG_WINDOW:   window_reg   <= pwdata[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_INTERVAL: prdata = interval_reg;
            REG_BURST:    prdata = {{(DATA_W-BURST_W){1'b0}}, burst_reg};
            REG_WINDOW:   prdata = {{(DATA_W-WIN_W){1'b0}}, window_reg};
            default:      prdata = '0;
        endcase
    end

    assign cfg.interval = interval_reg;
    assign cfg.burst    = burst_reg;
    assign cfg.window   = window_reg;

endmodule

// ===== hdl/strw_ctrl.sv =====
// strw_ctrl: sequencer for accept, history walk and result hand-off
// depends on strw_pkg
`timescale 1ns / 1ps

module strw_ctrl
    import strw_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  strw_stat_t stat,
    output strw_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    state_t state_reg;
    logic   ready_reg;

    assign s_tready   = ready_reg;
    assign cmd.start  = s_tvalid && ready_reg;
    assign cmd.walk   = (state_reg == ST_WALK);
    assign cmd.finish = (state_reg == ST_FINISH) && !stat.out_busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && ready_reg) begin
                        state_reg <= ST_WALK;
                        ready_reg <= 1'b0;
                    end else begin
                        ready_reg <= 1'b1;
                    end
                end
                ST_WALK: begin
                    if (stat.walk_done) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (!stat.out_busy) begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                    ready_reg <= 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== hdl/strw_dp.sv =====
// strw_dp: time history memory, counters, window walk and result register
// depends on strw_pkg
`timescale 1ns / 1ps

module strw_dp
    import strw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  strw_cfg_t             cfg,
    input  strw_cmd_t             cmd,
    output strw_stat_t            stat,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic [TIME_W-1:0] mem [HIST_DEPTH];
    logic [TIME_W-1:0] rdata_reg;

    logic [COUNT_W-1:0] counter_reg;
    logic [HEAD_W-1:0]  head_reg;
    logic [FILL_W-1:0]  fill_reg;

    logic               op_reg;
    logic [TIME_W-1:0]  now_reg;

    // walk control
    logic [HEAD_W-1:0] rd_addr_reg;
    logic [FILL_W-1:0] rd_n_reg;
    logic              rv_reg;
    logic              stop_reg;
    logic [WC_W-1:0]   wc_reg;

    logic              out_valid_reg;
    logic              snap_reg;
    logic [CAUSE_W-1:0] cause_reg;
    logic [COUNT_W-1:0] cnt_out_reg;
    logic [WC_W-1:0]   wc_out_reg;

    logic               wr_en;
    logic               issue;
    logic               compare;
    logic [TIME_W-1:0]  age;
    logic               in_win;
    logic [CAUSE_W-1:0] cause_next;
    logic [HEAD_W-1:0]  head_inc;
    logic [HEAD_W-1:0]  head_dec;
    logic [HEAD_W-1:0]  rd_addr_dec;

    assign wr_en   = cmd.start && (s_tuser == OP_WRITE);
    assign issue   = cmd.walk && !stop_reg && (rd_n_reg < fill_reg);
    assign compare = cmd.walk && rv_reg && !stop_reg;
    assign age     = now_reg - rdata_reg;
    assign in_win  = (age <= {{(TIME_W-WIN_W){1'b0}}, cfg.window});

    assign head_inc    = (head_reg == HEAD_W'(HIST_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign head_dec    = (head_reg == '0) ? HEAD_W'(HIST_DEPTH - 1) : head_reg - 1'b1;
    assign rd_addr_dec = (rd_addr_reg == '0) ? HEAD_W'(HIST_DEPTH - 1)
                                             : rd_addr_reg - 1'b1;

    assign stat.walk_done = stop_reg || (!rv_reg && (rd_n_reg == fill_reg));
    assign stat.out_busy  = out_valid_reg && !m_tready;

    always_comb begin
        if (op_reg == OP_FORCE) begin
            cause_next = CAUSE_FORCED;
        end else begin
            cause_next = CAUSE_NONE;
            if (counter_reg >= cfg.interval) begin
                cause_next = cause_next | CAUSE_COUNT;
            end
            if (wc_reg > {1'b0, cfg.burst}) begin
                cause_next = cause_next | CAUSE_BURST;
            end
        end
    end

    // history memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[head_reg] <= s_tdata;
        end
        if (issue) begin
            rdata_reg <= mem[rd_addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg  <= s_tuser;
            now_reg <= s_tdata;
            // newest stored time sits just below the head after the write
            rd_addr_reg <= (s_tuser == OP_WRITE) ? head_reg : head_dec;
        end else if (issue) begin
            rd_addr_reg <= rd_addr_dec;
        end
        if (cmd.finish) begin
            snap_reg    <= (cause_next != CAUSE_NONE);
            cause_reg   <= cause_next;
            cnt_out_reg <= counter_reg;
            wc_out_reg  <= wc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg   <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            rd_n_reg      <= '0;
            rv_reg        <= 1'b0;
            stop_reg      <= 1'b0;
            wc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.start) begin
                rd_n_reg <= '0;
                rv_reg   <= 1'b0;
                stop_reg <= 1'b0;
                wc_reg   <= '0;
                if (s_tuser == OP_WRITE) begin
                    counter_reg <= counter_reg + 1'b1;
                    head_reg    <= head_inc;
                    if (fill_reg < FILL_W'(HIST_DEPTH)) begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                end
            end else if (cmd.walk) begin
                rv_reg <= issue;
                if (issue) begin
                    rd_n_reg <= rd_n_reg + 1'b1;
                end
                if (compare) begin
                    // first time outside the window ends the walk
                    if (in_win) begin
                        wc_reg <= wc_reg + 1'b1;
                    end else begin
                        stop_reg <= 1'b1;
                    end
                end
            end

            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
                if (cause_next != CAUSE_NONE) begin
                    counter_reg <= '0;
                    head_reg    <= '0;
                    fill_reg    <= '0;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-1-CAUSE_W-COUNT_W-WC_W){1'b0}},
                       wc_out_reg, cnt_out_reg, cause_reg, snap_reg};

`ifndef NO_ASSERTIONS
    a_wc_le_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.walk |-> (wc_reg <= fill_reg))
        else $error("window count exceeds history fill");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(HIST_DEPTH))
        else $error("history fill beyond depth");

    a_clear_on_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish && (cause_next != CAUSE_NONE) |=>
            (fill_reg == '0) && (counter_reg == '0) && (head_reg == '0))
        else $error("state not cleared after snapshot");

    a_snap_matches_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (snap_reg == (cause_reg != CAUSE_NONE)))
        else $error("snapshot flag disagrees with cause");
`endif

endmodule

// ===== hdl/snapshot_trigger_rate_window_top.sv =====
// snapshot_trigger_rate_window_top: snapshot trigger on op count or burst rate
// depends on strw_pkg, strw_regs, strw_ctrl, strw_dp
//
// channel   direction  handshake          payload
// s_        in         s_tvalid/s_tready  s_tdata now_ms, s_tuser op
// m_        out        m_tvalid/m_tready  m_tdata snapshot, cause, op_count, window_count
// apb       in         psel/penable       0x0 interval, 0x4 burst limit, 0x8 window ms
//
// one request at a time; its duration is set by the single read port of the time memory
// walking one stored time per cycle and stopping at the first time outside the window
// or at the oldest stored time.
// reset is synchronous on aresetn; the history needs no clearing pass.
// a finished result waits in the output register while the next request is taken;
// the walk result is held back only while that register is still full.
`timescale 1ns / 1ps

module snapshot_trigger_rate_window_top
    import strw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] now_ms
    input  logic                  s_tuser,   // [0] op
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [0] snapshot, [3:1] cause,
                                             // [35:4] op_count, [44:36] window_count
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready
);

    strw_cfg_t  cfg;
    strw_cmd_t  cmd;
    strw_stat_t stat;

    strw_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    strw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    strw_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
